FILE: hdl/rrca_pkg.sv
// ----------------------------------------------------------------------------
// rrca_pkg
// Shared types, codes and constants of the read region cache allocator.
// ----------------------------------------------------------------------------
package rrca_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 1024;
  localparam int unsigned DIRECT_MAX_DEF    = 65536;

  localparam logic [31:0] GROW_BELOW   = 32'h0000_8000;
  localparam logic [16:0] GROW_TARGET  = 17'h1_0000;
  localparam logic [31:0] BASE_RST     = 32'h1100_0000;
  localparam logic [24:0] LIMIT_RST    = 25'h1E8_0000;

  localparam int unsigned GROW_LEN_W   = 15;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_SEEK  = 2'd1,
    CMD_INVAL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_DIRECT = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CACHE_ENABLE = 3'd0,
    REG_IMAGE_OPEN   = 3'd1,
    REG_BUFFER_BASE  = 3'd2,
    REG_BUFFER_LIMIT = 3'd3,
    REG_IMAGE_SHIFT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] place;
  } entry_t;

endpackage

FILE: hdl/rrca_table.sv
// ----------------------------------------------------------------------------
// rrca_table
// Region table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrca_table
  import rrca_pkg::*;
#(
  parameter int unsigned ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/rrca_rem.sv
// ----------------------------------------------------------------------------
// rrca_rem
// Bit-serial restoring remainder of 0x10000 by a short read length.
// ----------------------------------------------------------------------------
module rrca_rem
  import rrca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [GROW_LEN_W-1:0] divisor,
  output logic                  done,
  output logic [GROW_LEN_W-1:0] rem
);

  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] TOP_BIT = STEP_W'(16);

  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [GROW_LEN_W-1:0] rem_r, rem_nxt;
  logic [GROW_LEN_W-1:0] div_r, div_nxt;
  logic [GROW_LEN_W:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    // dividend is 0x10000: only its top bit is set
    trial    = {rem_r, (step_r == TOP_BIT)};
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = TOP_BIT;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[GROW_LEN_W-1:0];
      if (step_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: hdl/read_region_cache_allocator_core.sv
// ----------------------------------------------------------------------------
// read_region_cache_allocator_core
// Region cache allocator: table scan, prefetch growth and bump allocation.
// ----------------------------------------------------------------------------
// Seek, invalidate, unused commands and uncached reads: result in the cycle after start.
// Cached read: table scan of one entry per cycle over the filled entries, to a
// hit or a miss; on a miss, growth of a short read runs in the serial remainder
// unit. One transaction at a time; busy is high during a cached read and drops
// with its result strobe. Synchronous reset empties the table at once through
// its fill count.
module read_region_cache_allocator_core
  import rrca_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF,
  parameter int unsigned DIRECT_MAX    = DIRECT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_offset,
  input  logic [31:0] in_length,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_data_address,
  output logic [31:0] out_granted_length,
  output logic [63:0] out_fetch_offset,
  output logic        out_flushed,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [31:0]      DMAX     = 32'(DIRECT_MAX);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CACHE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [1:0] {IDLE, SCAN, GROW, ALLOC} state_t;

  state_t state_r, state_nxt;

  // configuration
  logic        cache_en_r, image_open_r;
  logic [31:0] base_r;
  logic [24:0] limit_r;
  logic [63:0] shift_r;

  // allocator state
  logic [31:0]      fill_r, fill_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [63:0]      prev_end_r, prev_end_nxt;

  // request
  logic [31:0]      off_r, off_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [31:0]      end_r, end_nxt;
  logic [63:0]      fetch_r, fetch_nxt;
  logic [31:0]      grant_r, grant_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_r, pend_nxt;

  // result
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] olen_r, olen_nxt;
  logic [63:0] ofetch_r, ofetch_nxt;
  logic        flushed_r, flushed_nxt;

  // table and remainder unit
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      wr_idx;
  entry_t                rd_data, wr_data;
  logic                  rem_start, rem_done;
  logic [GROW_LEN_W-1:0] rem_val;

  logic [63:0] fetch_calc;
  logic [31:0] direct_len;
  logic        hit_now;
  logic [32:0] fill_sum;
  logic        need_flush;
  logic [31:0] fill_base;
  logic [IDX_W-1:0] slot_use;
  logic [CNT_W-1:0] count_base;

  assign fetch_calc = {32'd0, in_offset} + shift_r;
  assign direct_len = (in_length > DMAX) ? DMAX : in_length;
  assign hit_now    = pend_r && (rd_data.size != '0) && (off_r >= rd_data.start) &&
                      (end_r <= rd_data.start + rd_data.size);
  assign fill_sum   = {1'b0, fill_r} + {1'b0, grant_r};
  assign need_flush = fill_sum >= {8'd0, limit_r};
  assign fill_base  = need_flush ? '0 : fill_r;
  assign slot_use   = need_flush ? '0 : slot_r;
  assign count_base = need_flush ? '0 : count_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    prev_end_nxt  = prev_end_r;
    off_nxt       = off_r;
    len_nxt       = len_r;
    end_nxt       = end_r;
    fetch_nxt     = fetch_r;
    grant_nxt     = grant_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    olen_nxt      = olen_r;
    ofetch_nxt    = ofetch_r;
    flushed_nxt   = flushed_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_idx        = slot_use;
    wr_data       = '{start: off_r, size: grant_r, place: base_r + fill_base};
    rem_start     = 1'b0;

    case (state_r)
      IDLE: begin
        if (start) begin
          off_nxt     = in_offset;
          len_nxt     = in_length;
          end_nxt     = in_offset + in_length;
          fetch_nxt   = fetch_calc;
          scan_nxt    = '0;
          status_nxt  = ST_DONE;
          addr_nxt    = '0;
          olen_nxt    = '0;
          ofetch_nxt  = '0;
          flushed_nxt = 1'b0;
          case (cmd_t'(in_command))
            CMD_SEEK: begin
              if (image_open_r) begin
                prev_end_nxt = fetch_calc;
              end
              out_valid_nxt = 1'b1;
            end
            CMD_INVAL: begin
              fill_nxt      = '0;
              slot_nxt      = '0;
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            CMD_READ: begin
              if (!cache_en_r) begin
                if (image_open_r) begin
                  prev_end_nxt = {32'd0, in_offset} + {32'd0, direct_len};
                end
                status_nxt    = ST_DIRECT;
                olen_nxt      = direct_len;
                ofetch_nxt    = {32'd0, in_offset};
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      SCAN: begin
        if (hit_now) begin
          status_nxt    = ST_HIT;
          addr_nxt      = rd_data.place + (off_r - rd_data.start);
          olen_nxt      = len_r;
          out_valid_nxt = 1'b1;
          state_nxt     = IDLE;
        end else if (scan_r < count_r) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else if (!pend_r) begin
          // miss: grow a short read that continues the previous fetch
          grant_nxt = len_r;
          if ((fetch_r == prev_end_r) && (len_r < GROW_BELOW) && (len_r != '0)) begin
            rem_start = 1'b1;
            state_nxt = GROW;
          end else begin
            state_nxt = ALLOC;
          end
        end
      end
      GROW: begin
        if (rem_done) begin
          // smallest multiple of the length at or above 0x10000
          grant_nxt = (rem_val == '0) ? {15'd0, GROW_TARGET} :
                      {15'd0, GROW_TARGET} + len_r - {17'd0, rem_val};
          state_nxt = ALLOC;
        end
      end
      ALLOC: begin
        wr_en     = 1'b1;
        slot_nxt  = (slot_use == IDX_LAST) ? '0 : slot_use + 1'b1;
        count_nxt = (count_base == CNT_FULL) ? CNT_FULL : count_base + 1'b1;
        fill_nxt  = fill_base + grant_r;
        if (image_open_r) begin
          prev_end_nxt = fetch_r + {32'd0, grant_r};
        end
        status_nxt    = ST_MISS;
        addr_nxt      = base_r + fill_base;
        olen_nxt      = grant_r;
        ofetch_nxt    = fetch_r;
        flushed_nxt   = need_flush;
        out_valid_nxt = 1'b1;
        state_nxt     = IDLE;
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      fill_r       <= '0;
      slot_r       <= '0;
      count_r      <= '0;
      prev_end_r   <= '1;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      cache_en_r   <= 1'b0;
      image_open_r <= 1'b0;
      base_r       <= BASE_RST;
      limit_r      <= LIMIT_RST;
      shift_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      slot_r      <= slot_nxt;
      count_r     <= count_nxt;
      prev_end_r  <= prev_end_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CACHE_ENABLE: cache_en_r   <= cfg_data[0];
          REG_IMAGE_OPEN:   image_open_r <= cfg_data[0];
          REG_BUFFER_BASE:  base_r       <= cfg_data[31:0];
          REG_BUFFER_LIMIT: limit_r      <= cfg_data[24:0];
          REG_IMAGE_SHIFT:  shift_r      <= cfg_data;
          default: ;
        endcase
      end
    end
    off_r     <= off_nxt;
    len_r     <= len_nxt;
    end_r     <= end_nxt;
    fetch_r   <= fetch_nxt;
    grant_r   <= grant_nxt;
    scan_r    <= scan_nxt;
    status_r  <= status_nxt;
    addr_r    <= addr_nxt;
    olen_r    <= olen_nxt;
    ofetch_r  <= ofetch_nxt;
    flushed_r <= flushed_nxt;
  end

  rrca_table #(
    .ENTRIES (CACHE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (scan_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  rrca_rem u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .divisor (len_r[GROW_LEN_W-1:0]),
    .done    (rem_done),
    .rem     (rem_val)
  );

  assign busy               = (state_r != IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_data_address   = addr_r;
  assign out_granted_length = olen_r;
  assign out_fetch_offset   = ofetch_r;
  assign out_flushed        = flushed_r;

endmodule

FILE: bench/read_region_cache_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_region_cache_allocator_checker
// Watches the request, result and register ports of the allocator and keeps
// its own copy of the region table and registers. Every accepted request
// gets a predicted result. Results are compared field by field, in order.
// ----------------------------------------------------------------------------
module read_region_cache_allocator_checker
  import rrca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_offset,
  input  logic [31:0] in_length,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_data_address,
  input  logic [31:0] out_granted_length,
  input  logic [63:0] out_fetch_offset,
  input  logic        out_flushed,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int unsigned ENTRIES = CACHE_ENTRIES_DEF;
  localparam logic [31:0] DMAX    = DIRECT_MAX_DEF;

  typedef struct {
    status_t     status;
    logic [31:0] addr;
    logic [31:0] granted;
    logic [63:0] fetch;
    logic        flushed;
  } reply_t;

  // shadow registers
  logic        en_q;
  logic        open_q;
  logic [31:0] base_q;
  logic [24:0] limit_q;
  logic [63:0] shift_q;

  // shadow region table
  logic [31:0] region_lo   [ENTRIES];
  logic [31:0] region_len  [ENTRIES];
  logic [31:0] region_addr [ENTRIES];
  logic [31:0] fill_q;
  logic [31:0] slot_q;
  logic [63:0] prev_end_q;

  reply_t replies_due[$];

  task automatic empty_regions();
    for (int k = 0; k < ENTRIES; k++) region_len[k] = '0;
    fill_q = '0;
    slot_q = '0;
  endtask

  task automatic serve_request(input logic [1:0] cmd, input logic [31:0] off,
                               input logic [31:0] len, output reply_t r);
    logic [31:0] req_end;
    logic [31:0] gr;
    logic [31:0] times;
    logic [31:0] slot;
    logic [63:0] fetch;
    logic        fl;
    bit          found;
    r = '{ST_DONE, 32'd0, 32'd0, 64'd0, 1'b0};
    case (cmd)
      CMD_SEEK: begin
        if (open_q) prev_end_q = {32'd0, off} + shift_q;
      end
      CMD_INVAL: empty_regions();
      CMD_READ: begin
        if (!en_q) begin
          gr = (len > DMAX) ? DMAX : len;
          if (open_q) prev_end_q = {32'd0, off} + {32'd0, gr};
          r = '{ST_DIRECT, 32'd0, gr, {32'd0, off}, 1'b0};
        end else begin
          req_end = off + len;
          found = 0;
          for (int k = 0; k < ENTRIES; k++) begin
            if (!found && region_len[k] != 0 && off >= region_lo[k] &&
                req_end <= region_lo[k] + region_len[k]) begin
              found = 1;
              r = '{ST_HIT, region_addr[k] + (off - region_lo[k]), len, 64'd0, 1'b0};
            end
          end
          if (!found) begin
            fetch = {32'd0, off} + shift_q;
            gr = len;
            fl = 0;
            // prefetch growth for short sequential reads
            if (fetch == prev_end_q && len < GROW_BELOW && len != 0) begin
              times = (32'h1_0000 + len - 1) / len;
              if (times < 2) times = 2;
              gr = times * len;
            end
            if (slot_q >= ENTRIES) slot_q = 0;
            if ({32'd0, fill_q} + {32'd0, gr} >= {39'd0, limit_q}) begin
              empty_regions();
              fl = 1;
            end
            slot = slot_q;
            slot_q = slot + 1;
            region_addr[slot] = base_q + fill_q;
            region_lo[slot] = off;
            region_len[slot] = gr;
            if (open_q) prev_end_q = fetch + {32'd0, gr};
            fill_q = fill_q + gr;
            r = '{ST_MISS, region_addr[slot], gr, fetch, fl};
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      en_q = 0;
      open_q = 0;
      base_q = BASE_RST;
      limit_q = LIMIT_RST;
      shift_q = '0;
      for (int k = 0; k < ENTRIES; k++) begin
        region_lo[k] = '0;
        region_len[k] = '0;
        region_addr[k] = '0;
      end
      fill_q = '0;
      slot_q = '0;
      prev_end_q = '1;
      replies_due.delete();
    end else begin
      // result check first: a new transaction can start at the strobe edge
      if (out_valid) begin
        got = '{status_t'(out_status), out_data_address, out_granted_length,
                out_fetch_offset, out_flushed};
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result status=%0d addr=%h len=%h fetch=%h fl=%b",
                     $realtime, got.status, got.addr, got.granted, got.fetch, got.flushed);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.addr !== want.addr ||
              got.granted !== want.granted || got.fetch !== want.fetch ||
              got.flushed !== want.flushed) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d addr=%h len=%h fetch=%h fl=%b",
                       want.status, want.addr, want.granted, want.fetch, want.flushed);
              $display("  actual   status=%0d addr=%h len=%h fetch=%h fl=%b",
                       got.status, got.addr, got.granted, got.fetch, got.flushed);
            end
          end
        end
      end
      if (start && !busy) begin
        serve_request(in_command, in_offset, in_length, want);
        replies_due.push_back(want);
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CACHE_ENABLE: en_q = cfg_data[0];
          REG_IMAGE_OPEN:   open_q = cfg_data[0];
          REG_BUFFER_BASE:  base_q = cfg_data[31:0];
          REG_BUFFER_LIMIT: limit_q = cfg_data[24:0];
          REG_IMAGE_SHIFT:  shift_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending = replies_due.size();
  end

endmodule

FILE: bench/read_region_cache_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_region_cache_allocator_core_tb
// Drives read, seek, invalidate and unused requests through several register
// settings: a directed opening, then random traffic shaped for hits,
// sequential growth and buffer flushes. The checker scores the results.
// ----------------------------------------------------------------------------
module read_region_cache_allocator_core_tb;
  import rrca_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_offset;
  logic [31:0] in_length;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_data_address;
  logic [31:0] out_granted_length;
  logic [63:0] out_fetch_offset;
  logic        out_flushed;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          errors;
  int          pending;

  bit          gaps_on;
  logic [31:0] recent_off [$];
  logic [31:0] recent_len [$];

  read_region_cache_allocator_core dut (.*);

  read_region_cache_allocator_checker u_checker (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  // hold one request until the block takes it
  task automatic send(input cmd_t cmd, input logic [31:0] off, input logic [31:0] len);
    if (gaps_on && $urandom_range(99) < 33) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_command <= cmd;
    in_offset <= off;
    in_length <= len;
    do @(posedge clk); while (busy);
    if (cmd == CMD_READ) begin
      recent_off.push_back(off);
      recent_len.push_back(len);
      if (recent_off.size() > 16) begin
        void'(recent_off.pop_front());
        void'(recent_len.pop_front());
      end
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic en, input logic open, input logic [31:0] base,
                          input logic [24:0] limit, input logic [63:0] shift);
    logic [63:0] vals [5];
    vals = '{{63'd0, en}, {63'd0, open}, {32'd0, base}, {39'd0, limit}, shift};
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1;
      cfg_index <= reg_idx_t'(k);
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int          pick;
    int          h;
    logic [31:0] o;
    logic [31:0] span;
    pick = $urandom_range(99);
    if (pick < 35 && recent_off.size() > 0) begin
      // re-read inside a recent region
      h = $urandom_range(recent_off.size() - 1);
      span = recent_len[h] > 32'h4_0000 ? 32'h4_0000 : recent_len[h];
      o = recent_off[h] + $urandom_range(0, span / 2);
      send(CMD_READ, o, $urandom_range(0, span - (o - recent_off[h])));
    end else if (pick < 55) begin
      o = $urandom;
      send(CMD_SEEK, o, $urandom);
      send(CMD_READ, o, $urandom_range(1, 32'h7FFF));
    end else if (pick < 70 && recent_off.size() > 0) begin
      send(CMD_READ, recent_off[$] + recent_len[$], $urandom_range(0, 32'h9000));
    end else if (pick < 80) begin
      send(CMD_READ, $urandom, $urandom_range(0, 32'h2_0000));
    end else if (pick < 88) begin
      send(CMD_READ, $urandom, $urandom);
    end else if (pick < 92) begin
      send(CMD_INVAL, $urandom, $urandom);
    end else if (pick < 96) begin
      send(CMD_SEEK, $urandom, $urandom);
    end else begin
      send(CMD_NONE, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_command = CMD_READ;
    in_offset = '0;
    in_length = '0;
    cfg_we = 0;
    cfg_index = REG_CACHE_ENABLE;
    cfg_data = '0;
    gaps_on = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: cache off, no image
    send(CMD_READ, 32'd0, 32'd0);
    send(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_READ, 32'd123, 32'h1_0000);
    send(CMD_READ, 32'd5, 32'h1_0001);
    send(CMD_SEEK, 32'h1234, 32'd0);
    send(CMD_INVAL, 32'd0, 32'd0);
    send(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // cache on, address wrap near top of memory
    set_regs(1, 1, 32'hFFFF_FFF0, 25'h3_0000, 64'hFFFF_FFFF_0000_1000);
    send(CMD_SEEK, 32'h1000, 32'd0);
    send(CMD_READ, 32'h1000, 32'h100);     // sequential, grows to 64 KiB
    send(CMD_READ, 32'h1080, 32'h80);      // hit
    send(CMD_READ, 32'h11000, 32'h7FFF);   // continues previous, grows again
    send(CMD_READ, 32'h4_0000, 32'd0);     // zero length, no growth
    send(CMD_READ, 32'h4_0000, 32'd0);
    send(CMD_READ, 32'd0, 32'h4_0000);     // overflows buffer, flush
    send(CMD_READ, 32'hFFFF_FFF0, 32'h20); // end wraps in hit test
    send(CMD_READ, 32'h5_0000, 32'h8000);
    send(CMD_READ, 32'h5_8000, 32'h8000);  // continuation at growth bound
    send(CMD_INVAL, 32'd0, 32'd0);
    send(CMD_NONE, 32'd0, 32'd0);
    send(CMD_READ, 32'd0, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(1, 1, $urandom, 25'h8_0000, 64'd0);
        1: set_regs(1, 1, 32'hFFFF_0000, LIMIT_RST, {$urandom, $urandom});
        2: set_regs(0, 1, 32'd0, 25'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        3: set_regs(1, 0, $urandom, 25'd0, {$urandom, $urandom});
        4: set_regs(1, 1, 32'd0, 25'h20_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        default: set_regs(1, 1, $urandom, 25'($urandom_range(0, LIMIT_RST)),
                          {$urandom, $urandom});
      endcase
      gaps_on = (p != 1);
      for (int n = 0; n < 80; n++) random_request();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
hdl/rrca_pkg.sv
hdl/rrca_table.sv
hdl/rrca_rem.sv
hdl/read_region_cache_allocator_core.sv
bench/read_region_cache_allocator_checker.sv
bench/read_region_cache_allocator_core_tb.sv
